/* rtl/axsort_pkg.sv */
`timescale 1ns / 1ps
// Package for the ascending exchange sorter.
// Element type and width used by the sorter's top level; no dependencies.

package axsort_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

endpackage : axsort_pkg

/* rtl/axsort_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.

module axsort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : axsort_ram

/* rtl/ascending_exchange_sorter.sv */
`timescale 1ns / 1ps
// Ascending exchange sorter, top level.
// Depends on axsort_pkg (element type) and axsort_ram (element buffer).
//
// Usage:
//   Input channel (in_*): one signed 32-bit value per beat, in_tlast closes
//   the set. Values arriving once DEPTH entries are held are dropped and the
//   set is flagged as overflowed (this includes the closing beat).
//   Output channel (out_*): the stored values in ascending signed order, one
//   per beat, out_tlast on the final one, out_tuser[0] = overflow flag of
//   the set. Equal values can change their relative order.
// Sequence, for a set of n stored values:
//   fill (one beat per cycle), then for each output position i: fetch buf[i]
//   (S_LOAD, S_FIRST), compare it against each later stored value (S_SCAN),
//   load the output register (S_EMIT) and wait for the output beat (S_WAIT).
//   The single comparator and the single read port of the buffer give one
//   compare per cycle.
// in_tready is high only while a set is being filled. A stalled receiver
// simply holds the block in its output wait; nothing is lost.
// Reset (rst_n low, synchronous) empties the buffer count, clears the
// overflow flag and returns to the fill state; buffer contents are left.

module ascending_exchange_sorter #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_value
  input  logic        in_tlast,   // is_last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,  // last_out
  output logic [0:0]  out_tuser   // [0] overflow
);

  import axsort_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [2:0] {
    S_FILL,   // taking input beats
    S_LOAD,   // read buf[i]
    S_FIRST,  // capture buf[i], read buf[i+1]
    S_SCAN,   // one compare of the running minimum against buf[j] per cycle
    S_EMIT,   // load output register with the minimum for position i
    S_WAIT    // output beat pending
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;   // entries held, also n while sorting
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt;           // output position
  logic [CW-1:0] j_r, j_nxt;           // index of the word on rd_data
  value_t        cur_r, cur_nxt;       // running minimum for position i
  logic          out_valid_r, out_valid_nxt;
  value_t        out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  // buffer port signals
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  value_t        wr_data;
  logic [AW-1:0] rd_addr;
  value_t        rd_data;

  logic          in_fire;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] j_inc;

  assign in_fire = in_tvalid && in_tready;
  assign i_inc   = i_r + ONE_C;
  assign j_inc   = j_r + ONE_C;

  axsort_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = value_t'(in_tdata);
    rd_addr       = i_r[AW-1:0];

    case (state_r)
      S_FILL: begin
        if (in_fire) begin
          if (count_r < DEPTH_C) begin
            wr_en     = 1'b1;
            count_nxt = count_r + ONE_C;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            i_nxt     = '0;
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        rd_addr   = i_r[AW-1:0];
        state_nxt = S_FIRST;
      end
      S_FIRST: begin
        cur_nxt = rd_data;
        rd_addr = i_inc[AW-1:0];
        j_nxt   = i_inc;
        // last position has nothing left to compare against
        state_nxt = (i_inc >= count_r) ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        // earlier value greater: swap, the smaller one stays in cur_r
        if (cur_r > rd_data) begin
          wr_en   = 1'b1;
          wr_addr = j_r[AW-1:0];
          wr_data = cur_r;
          cur_nxt = rd_data;
        end
        rd_addr = j_inc[AW-1:0];
        j_nxt   = j_inc;
        if (j_inc >= count_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = cur_r;
        out_last_nxt  = (i_inc == count_r);
        out_ovf_nxt   = ovf_r;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_FILL;
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_tready    = (state_r == S_FILL);
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_ovf_r;

endmodule : ascending_exchange_sorter
